### src/weighted_union_find_unit_macros.svh
// Assertion macros shared by the weighted union-find unit.
`ifndef WEIGHTED_UNION_FIND_UNIT_MACROS_SVH
`define WEIGHTED_UNION_FIND_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define WUF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define WUF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/wuf_pkg.sv
// Shared constants, codes and control types of the weighted union-find unit.
package wuf_pkg;

  localparam int MaxNodesDefault = 64;
  localparam int NodeW   = 6;
  localparam int CountW  = 7;
  localparam int SizeW   = 7;
  localparam int StatusW = 2;

  localparam logic ActQuery = 1'b0;
  localparam logic ActUnion = 1'b1;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusSame  = 2'd1;
  localparam logic [StatusW-1:0] StatusRange = 2'd2;

  typedef enum logic [1:0] {
    RdCur,
    RdData,
    RdSecond
  } rd_sel_e;

  typedef struct packed {
    logic    clr;
    logic    capture;
    rd_sel_e p_rd_sel;
    logic    halve;
    logic    root_a;
    logic    root_b;
    logic    s_rd_rb;
    logic    link;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oor;
    logic is_root;
    logic same_b;
    logic union_op;
    logic out_free;
  } sts_t;

endpackage

### src/wuf_if.sv
// Valid/ready channels carrying the request and result words.
interface wuf_in_if;
  import wuf_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [NodeW-1:0] first_node;
  logic [NodeW-1:0] second_node;

  modport source (output valid, action, first_node, second_node, input ready);
  modport sink (input valid, action, first_node, second_node, output ready);
endinterface

interface wuf_out_if;
  import wuf_pkg::*;

  logic               valid;
  logic               ready;
  logic               connected;
  logic [NodeW-1:0]   root_of_first;
  logic [NodeW-1:0]   root_of_second;
  logic [StatusW-1:0] status;

  modport source (output valid, connected, root_of_first, root_of_second, status,
                  input ready);
  modport sink (input valid, connected, root_of_first, root_of_second, status,
                output ready);
endinterface

### src/weighted_union_find_unit.sv
// Weighted union-find unit: a disjoint-set engine over up to MAX_NODES nodes, each
// node its own root after reset. Each request word either asks whether two nodes are
// connected or joins their sets, and yields exactly one result word with both roots
// found before any merge and a status. Finds walk the parent table with path halving
// (a step moves to the grandparent, or to the root when the parent is the root), each
// step reading the parent and then the grandparent, because the parent table has one
// read port with a registered read; a union then reads both subtree sizes and writes
// the link. A word with a node out of range goes from the range check straight to its
// result. With 64 nodes a tree is at most six levels deep, so a walk takes at most
// three steps. After reset the tables are cleared one entry per cycle, and no request
// is accepted until they are clear; node_count may be written at any time the unit is
// idle. A finished result waits in an output register, so a new request is taken
// while it is still unread; the unit only stalls before loading the next result
// while the previous one is still unread.
`include "weighted_union_find_unit_macros.svh"

module weighted_union_find_unit #(
  parameter int MAX_NODES = wuf_pkg::MaxNodesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wuf_pkg::CountW-1:0] cfg_wdata_i,
  wuf_in_if.sink                     item_i,
  wuf_out_if.source                  result_o
);
  import wuf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wuf_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (item_i.action),
    .first_node_i     (item_i.first_node),
    .second_node_i    (item_i.second_node),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .connected_o      (result_o.connected),
    .root_of_first_o  (result_o.root_of_first),
    .root_of_second_o (result_o.root_of_second),
    .status_o         (result_o.status)
  );

  `WUF_ASSERT_NXT(a_busy_after_accept, item_i.valid && item_i.ready, !item_i.ready, "accepted a second word without processing the first")
  `WUF_ASSERT_IMP(a_range_zeroes, result_o.valid && result_o.status == StatusRange, !result_o.connected && result_o.root_of_first == '0 && result_o.root_of_second == '0, "out-of-range result carries non-zero fields")
  `WUF_ASSERT_IMP(a_connected_roots, result_o.valid && result_o.connected, result_o.root_of_first == result_o.root_of_second, "connected result with differing roots")

endmodule

### src/wuf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module wuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/wuf_dp.sv
// Datapath: parent and size tables, walk registers, range check and result register.
module wuf_dp #(
  parameter int MAX_NODES = wuf_pkg::MaxNodesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wuf_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                        action_i,
  input  logic [wuf_pkg::NodeW-1:0]   first_node_i,
  input  logic [wuf_pkg::NodeW-1:0]   second_node_i,
  input  wuf_pkg::cmd_t               cmd_i,
  output wuf_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        connected_o,
  output logic [wuf_pkg::NodeW-1:0]   root_of_first_o,
  output logic [wuf_pkg::NodeW-1:0]   root_of_second_o,
  output logic [wuf_pkg::StatusW-1:0] status_o
);
  import wuf_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int LimInt = (MAX_NODES < (1 << NodeW)) ? MAX_NODES : (1 << NodeW);
  localparam logic [NodeW:0] NodeLim = (NodeW + 1)'(LimInt);

  logic [CountW-1:0]  node_count_q;
  logic [AW-1:0]      clr_cnt_q;
  logic               act_q;
  logic [NodeW-1:0]   a_q, b_q;
  logic [AW-1:0]      cur_q, ra_q, rb_q;
  logic [SizeW-1:0]   sa_q;
  logic               out_valid_q;
  logic               connected_q;
  logic [NodeW-1:0]   root_a_q, root_b_q;
  logic [StatusW-1:0] status_q;

  logic [AW-1:0]    p_rdata, p_raddr, p_waddr, p_wdata;
  logic             p_we;
  logic [SizeW-1:0] s_rdata, s_wdata;
  logic [AW-1:0]    s_raddr, s_waddr;
  logic             s_we;
  logic             a_smaller, a_ok, b_ok, oor, same;
  logic [AW-1:0]    winner, loser;

  assign a_ok = ({1'b0, a_q} < NodeLim) && ({1'b0, a_q} < node_count_q);
  assign b_ok = ({1'b0, b_q} < NodeLim) && ({1'b0, b_q} < node_count_q);
  assign oor  = !(a_ok && b_ok);
  assign same = (ra_q == rb_q);

  assign a_smaller = (sa_q < s_rdata);
  assign winner    = a_smaller ? rb_q : ra_q;
  assign loser     = a_smaller ? ra_q : rb_q;

  always_comb begin
    case (cmd_i.p_rd_sel)
      RdCur:    p_raddr = cur_q;
      RdData:   p_raddr = p_rdata;
      RdSecond: p_raddr = AW'(b_q);
      default:  p_raddr = cur_q;
    endcase
  end

  always_comb begin
    p_we    = cmd_i.clr || cmd_i.halve || cmd_i.link;
    p_waddr = loser;
    p_wdata = winner;
    if (cmd_i.clr) begin
      p_waddr = clr_cnt_q;
      p_wdata = clr_cnt_q;
    end else if (cmd_i.halve) begin
      p_waddr = cur_q;
      p_wdata = p_rdata;
    end
  end

  assign s_raddr = cmd_i.s_rd_rb ? rb_q : ra_q;
  assign s_we    = cmd_i.clr || cmd_i.link;
  assign s_waddr = cmd_i.clr ? clr_cnt_q : winner;
  assign s_wdata = cmd_i.clr ? SizeW'(1) : SizeW'(sa_q + s_rdata);

  wuf_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  wuf_ram #(.WIDTH(SizeW), .DEPTH(MAX_NODES)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountW'(64);
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      a_q   <= first_node_i;
      b_q   <= second_node_i;
      cur_q <= AW'(first_node_i);
    end else if (cmd_i.halve) begin
      cur_q <= p_rdata;
    end else if (cmd_i.root_a) begin
      ra_q  <= cur_q;
      cur_q <= AW'(b_q);
    end
    if (cmd_i.root_b) begin
      rb_q <= cur_q;
    end
    if (cmd_i.s_rd_rb) begin
      sa_q <= s_rdata;
    end
    if (cmd_i.out_load) begin
      if (oor) begin
        connected_q <= 1'b0;
        root_a_q    <= '0;
        root_b_q    <= '0;
        status_q    <= StatusRange;
      end else begin
        connected_q <= same;
        root_a_q    <= NodeW'(ra_q);
        root_b_q    <= NodeW'(rb_q);
        status_q    <= (act_q == ActUnion && same) ? StatusSame : StatusOk;
      end
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == AW'(MAX_NODES - 1));
  assign sts_o.oor      = oor;
  assign sts_o.is_root  = (p_rdata == cur_q);
  assign sts_o.same_b   = (ra_q == cur_q);
  assign sts_o.union_op = (act_q == ActUnion);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign connected_o      = connected_q;
  assign root_of_first_o  = root_a_q;
  assign root_of_second_o = root_b_q;
  assign status_o         = status_q;

endmodule

### src/wuf_ctrl.sv
// Controller: sequences table clearing, both root walks, the link step and result hand-off.
module wuf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wuf_pkg::sts_t sts_i,
  output wuf_pkg::cmd_t cmd_o
);
  import wuf_pkg::*;

  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SCheck = 4'd2;
  localparam logic [3:0] SParA  = 4'd3;
  localparam logic [3:0] SGrA   = 4'd4;
  localparam logic [3:0] SParB  = 4'd5;
  localparam logic [3:0] SGrB   = 4'd6;
  localparam logic [3:0] SSizeA = 4'd7;
  localparam logic [3:0] SSizeB = 4'd8;
  localparam logic [3:0] SDone  = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, p_rd_sel: RdCur};
    case (state_q)
      SClear: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SCheck;
        end
      end
      SCheck: begin
        state_d = sts_i.oor ? SDone : SParA;
      end
      SParA: begin
        if (sts_i.is_root) begin
          cmd_o.root_a   = 1'b1;
          cmd_o.p_rd_sel = RdSecond;
          state_d        = SParB;
        end else begin
          cmd_o.p_rd_sel = RdData;
          state_d        = SGrA;
        end
      end
      SGrA: begin
        cmd_o.halve    = 1'b1;
        cmd_o.p_rd_sel = RdData;
        state_d        = SParA;
      end
      SParB: begin
        if (sts_i.is_root) begin
          cmd_o.root_b = 1'b1;
          state_d      = (sts_i.union_op && !sts_i.same_b) ? SSizeA : SDone;
        end else begin
          cmd_o.p_rd_sel = RdData;
          state_d        = SGrB;
        end
      end
      SGrB: begin
        cmd_o.halve    = 1'b1;
        cmd_o.p_rd_sel = RdData;
        state_d        = SParB;
      end
      SSizeA: begin
        cmd_o.s_rd_rb = 1'b1;
        state_d       = SSizeB;
      end
      SSizeB: begin
        cmd_o.link = 1'b1;
        state_d    = SDone;
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule
